FILE: design/assert_macros.svh
// Concurrent assertion helpers; compile with NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside of reset.
`define ITST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ITST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ITST_ASSERT(lbl, clk, rst_n, prop, msg)
`define ITST_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: design/itst_pkg.sv
package itst_pkg;

  // Slot pool
  localparam int SLOT_COUNT  = 32;
  localparam int SLOT_W      = 6;
  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] SLOT_NIL = 6'd63;

  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int SEQ_W    = 32;
  localparam int RUN_W    = 32;
  localparam int BYTES_W  = 24;
  localparam int KIND_W   = 8;
  localparam int TAG_W    = 32;
  localparam int INC_W    = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Modes
  localparam logic [MODE_W-1:0] MODE_CHARGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_OPEN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STALE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_OPEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCARNATION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT        = 2'd2;

  localparam logic [TOTAL_W-1:0] LIMIT_RESET = 32'd1048576;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SEQ_W-1:0]    sequence_no;
    logic [BYTES_W-1:0]  bytes;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
  } slot_entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] stream_handle;
    logic [SEQ_W-1:0]    sequence_req;
    logic [RUN_W-1:0]    run_length;
    logic [BYTES_W-1:0]  byte_count;
    logic [KIND_W-1:0]   buffer_kind;
    logic [TAG_W-1:0]    buffer_tag;
    logic [INC_W-1:0]    incarnation;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                released;
    logic [KIND_W-1:0]   release_kind;
    logic [TAG_W-1:0]    release_tag;
    logic [BYTES_W-1:0]  release_bytes;
    logic                stalled;
    logic [TOTAL_W-1:0]  inflight_total;
    logic                last;
  } result_t;

endpackage

FILE: design/itst_ifs.sv
interface itst_in_if;
  logic                          valid;
  logic                          ready;
  logic [itst_pkg::MODE_W-1:0]   mode;
  logic [itst_pkg::HANDLE_W-1:0] stream_handle;
  logic [itst_pkg::SEQ_W-1:0]    sequence_req;
  logic [itst_pkg::RUN_W-1:0]    run_length;
  logic [itst_pkg::BYTES_W-1:0]  byte_count;
  logic [itst_pkg::KIND_W-1:0]   buffer_kind;
  logic [itst_pkg::TAG_W-1:0]    buffer_tag;
  logic [itst_pkg::INC_W-1:0]    incarnation;

  modport source (
    output valid, mode, stream_handle, sequence_req, run_length, byte_count,
           buffer_kind, buffer_tag, incarnation,
    input  ready
  );
  modport sink (
    input  valid, mode, stream_handle, sequence_req, run_length, byte_count,
           buffer_kind, buffer_tag, incarnation,
    output ready
  );
endinterface

interface itst_out_if;
  logic                          valid;
  logic                          ready;
  logic [itst_pkg::STATUS_W-1:0] status;
  logic                          released;
  logic [itst_pkg::KIND_W-1:0]   release_kind;
  logic [itst_pkg::TAG_W-1:0]    release_tag;
  logic [itst_pkg::BYTES_W-1:0]  release_bytes;
  logic                          stalled;
  logic [itst_pkg::TOTAL_W-1:0]  inflight_total;
  logic                          last;

  modport source (
    output valid, status, released, release_kind, release_tag, release_bytes,
           stalled, inflight_total, last,
    input  ready
  );
  modport sink (
    input  valid, status, released, release_kind, release_tag, release_bytes,
           stalled, inflight_total, last,
    output ready
  );
endinterface

interface itst_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [itst_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [itst_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: design/itst_slot_ram.sv
// Slot payload store: one write port, one registered read port.
module itst_slot_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [itst_pkg::SLOT_IDX_W-1:0] wr_addr,
  input  itst_pkg::slot_entry_t           wr_data,
  input  logic                            rd_en,
  input  logic [itst_pkg::SLOT_IDX_W-1:0] rd_addr,
  output itst_pkg::slot_entry_t           rd_data
);

  itst_pkg::slot_entry_t mem [itst_pkg::SLOT_COUNT];
  itst_pkg::slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/itst_link_ram.sv
// Free-list link store. An entry never written since reset reads as its
// power-up link (next slot, nil for the top slot), tracked by written bits.
module itst_link_ram (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [itst_pkg::SLOT_IDX_W-1:0] wr_addr,
  input  logic [itst_pkg::SLOT_W-1:0]     wr_data,
  input  logic                            rd_en,
  input  logic [itst_pkg::SLOT_IDX_W-1:0] rd_addr,
  output logic [itst_pkg::SLOT_W-1:0]     rd_data
);

  logic [itst_pkg::SLOT_W-1:0]     mem [itst_pkg::SLOT_COUNT];
  logic [itst_pkg::SLOT_COUNT-1:0] written_r;
  logic [itst_pkg::SLOT_W-1:0]     mem_q_r;
  logic [itst_pkg::SLOT_W-1:0]     dflt_q_r;
  logic                            use_mem_r;
  logic [itst_pkg::SLOT_W-1:0]     dflt;

  assign dflt = (rd_addr == itst_pkg::SLOT_IDX_W'(itst_pkg::SLOT_COUNT - 1))
              ? itst_pkg::SLOT_NIL
              : itst_pkg::SLOT_W'(rd_addr) + itst_pkg::SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r   <= mem[rd_addr];
      dflt_q_r  <= dflt;
      use_mem_r <= written_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = use_mem_r ? mem_q_r : dflt_q_r;

endmodule

FILE: design/tx_inflight_slot_tracker_core.sv
// In-flight slot tracker. Charges, refusals, malformed items and acknowledgements
// with a stale incarnation or a zero run length go from transfer to result via
// one link-memory read, then the update, which waits for a free output register.
// Other acknowledgements and drops walk the whole slot memory through its single
// read port, a read and an evaluation per slot, pausing while a second release
// waits on a stalled result side; one release is delivered per retired slot, and
// the final result of an item carries last. One item is worked on at a time; the
// next is taken once that result enters the output register, where it may still
// sit. No clearing pass runs after reset. Configuration writes are always taken.
`include "assert_macros.svh"

module tx_inflight_slot_tracker_core (
  input  logic              clk,
  input  logic              rst_n,
  itst_in_if.sink           in_ch,
  itst_out_if.source        out_ch,
  itst_cfg_if.sink          cfg_ch
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SINGLE  = 5'b00010,
    S_SCAN_RD = 5'b00100,
    S_SCAN_EV = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic                              open_r;
  logic [itst_pkg::INC_W-1:0]        inc_r;
  logic [itst_pkg::TOTAL_W-1:0]      limit_r;

  logic [itst_pkg::SLOT_COUNT-1:0]   valid_r, valid_nxt;
  logic [itst_pkg::SLOT_W-1:0]       free_head_r, free_head_nxt;
  logic [itst_pkg::TOTAL_W-1:0]      inflight_r, inflight_nxt;
  logic                              stall_r, stall_nxt;

  itst_pkg::req_t                    req_r, req_nxt;
  logic [itst_pkg::SLOT_IDX_W-1:0]   idx_r, idx_nxt;
  logic [itst_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  itst_pkg::result_t                 hold_r, hold_nxt;
  logic                              hold_vld_r, hold_vld_nxt;
  itst_pkg::result_t                 out_r, out_nxt;
  logic                              out_vld_r, out_vld_nxt;

  logic                              slot_wr_en;
  logic [itst_pkg::SLOT_IDX_W-1:0]   slot_wr_addr;
  itst_pkg::slot_entry_t             slot_wr_data;
  logic                              slot_rd_en;
  itst_pkg::slot_entry_t             slot_rd_data;

  logic                              link_wr_en;
  logic [itst_pkg::SLOT_IDX_W-1:0]   link_wr_addr;
  logic [itst_pkg::SLOT_W-1:0]       link_wr_data;
  logic                              link_rd_en;
  logic [itst_pkg::SLOT_W-1:0]       link_rd_data;

  logic                              in_xfer;
  logic                              out_free;
  logic                              head_ok;
  logic [itst_pkg::TOTAL_W:0]        charge_sum;
  logic [itst_pkg::SEQ_W-1:0]        seq_off;
  logic                              hit;
  logic [itst_pkg::TOTAL_W-1:0]      dec_total;
  logic                              scan_end;

  itst_slot_ram u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (slot_rd_en),
    .rd_addr (idx_r),
    .rd_data (slot_rd_data)
  );

  itst_link_ram u_link_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (link_rd_en),
    .rd_addr (free_head_r[itst_pkg::SLOT_IDX_W-1:0]),
    .rd_data (link_rd_data)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_vld_r || out_ch.ready;

  assign head_ok    = free_head_r < itst_pkg::SLOT_W'(itst_pkg::SLOT_COUNT);
  assign charge_sum = {1'b0, inflight_r} + (itst_pkg::TOTAL_W + 1)'(req_r.byte_count);
  assign seq_off    = slot_rd_data.sequence_no - req_r.sequence_req;
  assign hit        = valid_r[idx_r]
                   && (slot_rd_data.handle == req_r.stream_handle)
                   && ((req_r.mode == itst_pkg::MODE_DROP) || (seq_off < req_r.run_length));
  assign dec_total  = inflight_r - itst_pkg::TOTAL_W'(slot_rd_data.bytes);
  assign scan_end   = (idx_r == itst_pkg::SLOT_IDX_W'(itst_pkg::SLOT_COUNT - 1))
                   || (hit && (cnt_r == itst_pkg::CNT_W'(itst_pkg::MAX_RESULTS - 1)));

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    free_head_nxt = free_head_r;
    inflight_nxt  = inflight_r;
    stall_nxt     = stall_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    hold_vld_nxt  = hold_vld_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;

    slot_wr_en    = 1'b0;
    slot_wr_addr  = free_head_r[itst_pkg::SLOT_IDX_W-1:0];
    slot_wr_data  = '{handle:      req_r.stream_handle,
                      sequence_no: req_r.sequence_req,
                      bytes:       req_r.byte_count,
                      kind:        req_r.buffer_kind,
                      tag:         req_r.buffer_tag};
    slot_rd_en    = 1'b0;
    link_wr_en    = 1'b0;
    link_wr_addr  = free_head_r[itst_pkg::SLOT_IDX_W-1:0];
    link_wr_data  = itst_pkg::SLOT_NIL;
    link_rd_en    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt      = '{mode:          in_ch.mode,
                           stream_handle: in_ch.stream_handle,
                           sequence_req:  in_ch.sequence_req,
                           run_length:    in_ch.run_length,
                           byte_count:    in_ch.byte_count,
                           buffer_kind:   in_ch.buffer_kind,
                           buffer_tag:    in_ch.buffer_tag,
                           incarnation:   in_ch.incarnation};
          idx_nxt      = '0;
          cnt_nxt      = '0;
          hold_vld_nxt = 1'b0;
          link_rd_en   = head_ok;
          if ((in_ch.mode == itst_pkg::MODE_DROP)
              || ((in_ch.mode == itst_pkg::MODE_ACK) && (in_ch.incarnation == inc_r)
                  && (in_ch.run_length != '0))) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_SINGLE;
          end
        end
      end

      S_SINGLE: begin
        if (out_free) begin
          out_nxt = '0;
          case (req_r.mode)
            itst_pkg::MODE_CHARGE: begin
              if (!open_r) begin
                out_nxt.status = itst_pkg::ST_NOT_OPEN;
              end else if ((charge_sum > {1'b0, limit_r}) || !head_ok) begin
                stall_nxt      = 1'b1;
                out_nxt.status = itst_pkg::ST_FULL;
              end else begin
                slot_wr_en                                    = 1'b1;
                link_wr_en                                    = 1'b1;
                valid_nxt[free_head_r[itst_pkg::SLOT_IDX_W-1:0]] = 1'b1;
                free_head_nxt                                 = link_rd_data;
                inflight_nxt                                  = charge_sum[itst_pkg::TOTAL_W-1:0];
                out_nxt.status                                = itst_pkg::ST_OK;
              end
            end
            itst_pkg::MODE_ACK: begin
              out_nxt.status = (req_r.incarnation != inc_r) ? itst_pkg::ST_STALE
                                                             : itst_pkg::ST_MALFORMED;
            end
            default: begin
              out_nxt.status = itst_pkg::ST_MALFORMED;
            end
          endcase
          out_nxt.stalled        = stall_nxt;
          out_nxt.inflight_total = inflight_nxt;
          out_nxt.last           = 1'b1;
          out_vld_nxt            = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        slot_rd_en = 1'b1;
        state_nxt  = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        // a second release needs the output register to push the held one
        if (!(hit && hold_vld_r && !out_free)) begin
          if (hit) begin
            valid_nxt[idx_r] = 1'b0;
            link_wr_en       = 1'b1;
            link_wr_addr     = idx_r;
            link_wr_data     = free_head_r;
            free_head_nxt    = itst_pkg::SLOT_W'(idx_r);
            inflight_nxt     = dec_total;
            if (dec_total < limit_r) begin
              stall_nxt = 1'b0;
            end
            hold_nxt     = '{status:         itst_pkg::ST_OK,
                             released:       1'b1,
                             release_kind:   slot_rd_data.kind,
                             release_tag:    slot_rd_data.tag,
                             release_bytes:  slot_rd_data.bytes,
                             stalled:        stall_nxt,
                             inflight_total: dec_total,
                             last:           1'b0};
            hold_vld_nxt = 1'b1;
            cnt_nxt      = cnt_r + itst_pkg::CNT_W'(1);
            if (hold_vld_r) begin
              out_nxt     = hold_r;
              out_vld_nxt = 1'b1;
            end
          end
          if (scan_end) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + itst_pkg::SLOT_IDX_W'(1);
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          if (hold_vld_r) begin
            out_nxt = hold_r;
          end else begin
            out_nxt                = '0;
            out_nxt.status         = (req_r.mode == itst_pkg::MODE_ACK) ? itst_pkg::ST_NO_MATCH
                                                                         : itst_pkg::ST_OK;
            out_nxt.stalled        = stall_r;
            out_nxt.inflight_total = inflight_r;
          end
          out_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      inc_r       <= '0;
      limit_r     <= itst_pkg::LIMIT_RESET;
      valid_r     <= '0;
      free_head_r <= '0;
      inflight_r  <= '0;
      stall_r     <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      free_head_r <= free_head_nxt;
      inflight_r  <= inflight_nxt;
      stall_r     <= stall_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          itst_pkg::CFG_CHANNEL_OPEN: open_r  <= cfg_ch.wdata[0];
          itst_pkg::CFG_INCARNATION:  inc_r   <= cfg_ch.wdata;
          itst_pkg::CFG_LIMIT:        limit_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.released       = out_r.released;
  assign out_ch.release_kind   = out_r.release_kind;
  assign out_ch.release_tag    = out_r.release_tag;
  assign out_ch.release_bytes  = out_r.release_bytes;
  assign out_ch.stalled        = out_r.stalled;
  assign out_ch.inflight_total = out_r.inflight_total;
  assign out_ch.last           = out_r.last;

  // the free-list head never points at an occupied slot
  `ITST_ASSERT(a_head_free, clk, rst_n, head_ok |-> !valid_r[free_head_r[itst_pkg::SLOT_IDX_W-1:0]], "free head is occupied")
  // an accepted item always starts work on the next cycle
  `ITST_ASSERT(a_accept_start, clk, rst_n, in_xfer |=> (state_r == S_SINGLE || state_r == S_SCAN_RD), "accepted item not started")
  // no release is left parked between items
  `ITST_ASSERT(a_no_hold_idle, clk, rst_n, (state_r == S_IDLE || state_r == S_SINGLE) |-> !hold_vld_r, "held release left over")
  // a retirement always loads the held release
  `ITST_ASSERT(a_retire_hold, clk, rst_n, (state_r == S_SCAN_EV && hit && out_free) |=> hold_vld_r, "retired slot not held")

endmodule
